// ===== design/sem_pkg.sv =====
// Shared constants and types for the Sobel edge magnitude unit.
// No dependencies; imported by the top level.
package sem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 8;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 13;
	localparam int PEND_W    = 11;
	localparam int ADDR_W    = 3;
	localparam int MIN_SIZE  = 3;
	localparam int SAT_MAX   = 255;
	localparam int SUM_W     = PIX_W + 2;
	localparam int DIFF_W    = SUM_W + 1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

	// register select, taken from paddr[2]
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} item_kind_t;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== design/sem_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the line stores of the Sobel edge magnitude unit.
module sem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/sobel_edge_magnitude_unit.sv =====
// Streaming 3x3 Sobel edge detector, L1 magnitude saturated to 255. Gray pixels
// enter in raster order, one item per clock when the output side keeps up, and a
// result passes the stage 1, stage 2 and output registers (line store read, kernel
// sums, magnitude). The two previous rows sit in one 1024 x 16 line store, read at
// the column of each pixel and written back from stage 1; its unwritten entries
// only ever feed border outputs, so there is no clearing pass after reset. The first
// width+1 pixels of a frame give no output; after the last pixel, each drain item
// releases one of the width+1 zero border outputs still owed, the last one with tlast.
// Image size is set through the APB registers (width at 0x0, height at 0x4).
// Depends on sem_pkg and sem_ram.
module sobel_edge_magnitude_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sem_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// pixel stream in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] gray
	input  logic                            s_axis_tuser,  // [0] kind
	// edge stream out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [7:0] edge_res
	output logic                            m_axis_tlast
);

	import sem_pkg::*;

	// configuration
	logic [WIDTH_W-1:0]  img_width_q;
	logic [HEIGHT_W-1:0] img_height_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= WIDTH_RST;
			img_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_IMAGE_WIDTH:  img_width_q  <= pwdata[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: img_height_q <= pwdata[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_IMAGE_WIDTH:  prdata = 32'(img_width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(img_height_q);
			default:          prdata = '0;
		endcase
	end

	// effective sizes
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	always_comb begin
		w_eff = img_width_q;
		if (img_width_q < WIDTH_W'(MIN_SIZE)) w_eff = WIDTH_W'(MIN_SIZE);
		if (img_width_q > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
		h_eff = (img_height_q < HEIGHT_W'(MIN_SIZE)) ? HEIGHT_W'(MIN_SIZE) : img_height_q;
	end

	// pipeline advance: everything moves when the output register is free
	logic en;
	logic acc;
	logic is_pix;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && en;
	assign is_pix        = (item_kind_t'(s_axis_tuser) == KIND_PIXEL);

	// stage 0: position bookkeeping
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PEND_W-1:0]   pend_q;

	logic                emit;
	logic                border;
	logic                col_wrap;
	logic                row_wrap;
	logic                drain_res;
	logic                drain_last;
	logic [PEND_W-1:0]   pend_dec;

	always_comb begin
		emit     = (row_q >= HEIGHT_W'(2)) || (row_q == HEIGHT_W'(1) && col_q != '0);
		// center is (row-1, col-1)
		border   = (col_q == '0) || (col_q == COL_W'(1))
			|| (WIDTH_W'(col_q) >= w_eff)
			|| (row_q == HEIGHT_W'(1)) || (row_q >= h_eff);
		col_wrap = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= w_eff;
		row_wrap = ((HEIGHT_W+1)'(row_q) + (HEIGHT_W+1)'(1)) >= (HEIGHT_W+1)'(h_eff);
		pend_dec   = pend_q - PEND_W'(1);
		drain_res  = (pend_q != '0);
		drain_last = (pend_dec == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (acc) begin
			if (is_pix) begin
				pend_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					if (row_wrap) begin
						row_q  <= '0;
						pend_q <= PEND_W'(w_eff) + PEND_W'(1);
					end else begin
						row_q <= row_q + HEIGHT_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else if (drain_res) begin
				pend_q <= pend_dec;
			end
		end
	end

	// stage 1 registers
	logic             pix_s1;
	logic             res_s1;
	logic             zero_s1;
	logic             last_s1;
	pix_t             px_s1;
	logic [COL_W-1:0] col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			res_s1 <= 1'b0;
		end else if (en) begin
			pix_s1 <= acc && is_pix;
			res_s1 <= acc && (is_pix ? emit : drain_res);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= !is_pix || border;
			last_s1 <= !is_pix && drain_last;
			px_s1   <= s_axis_tdata;
			col_s1  <= col_q;
		end
	end

	// line store: [7:0] row above, [15:8] two rows above
	logic              ram_we;
	logic [2*PIX_W-1:0] ram_rdata;
	pix_t              up1;
	pix_t              up2;

	assign ram_we = en && pix_s1;
	assign up1    = ram_rdata[PIX_W-1:0];
	assign up2    = ram_rdata[2*PIX_W-1:PIX_W];

	sem_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata ({up1, px_s1}),
		.re    (en),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// stage 1: window shift and kernel sums
	pix_t win_q [9];
	pix_t win_n [9];

	always_comb begin
		win_n[0] = win_q[1];
		win_n[1] = win_q[2];
		win_n[2] = up2;
		win_n[3] = win_q[4];
		win_n[4] = win_q[5];
		win_n[5] = up1;
		win_n[6] = win_q[7];
		win_n[7] = win_q[8];
		win_n[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (en && pix_s1) begin
			for (int i = 0; i < 9; i++) win_q[i] <= win_n[i];
		end
	end

	logic [SUM_W-1:0]         sum_l, sum_r, sum_t, sum_b;
	logic signed [DIFF_W-1:0] dx, dy;

	always_comb begin
		sum_l = SUM_W'(win_n[0]) + (SUM_W'(win_n[3]) << 1) + SUM_W'(win_n[6]);
		sum_r = SUM_W'(win_n[2]) + (SUM_W'(win_n[5]) << 1) + SUM_W'(win_n[8]);
		sum_t = SUM_W'(win_n[0]) + (SUM_W'(win_n[1]) << 1) + SUM_W'(win_n[2]);
		sum_b = SUM_W'(win_n[6]) + (SUM_W'(win_n[7]) << 1) + SUM_W'(win_n[8]);
		dx    = $signed(DIFF_W'(sum_l)) - $signed(DIFF_W'(sum_r));
		dy    = $signed(DIFF_W'(sum_t)) - $signed(DIFF_W'(sum_b));
	end

	// stage 2 registers
	logic                     res_s2;
	logic                     zero_s2;
	logic                     last_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (en) begin
			res_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			last_s2 <= last_s1;
			dx_s2   <= dx;
			dy_s2   <= dy;
		end
	end

	// stage 2: L1 magnitude with saturation
	logic [SUM_W-1:0]   abs_dx, abs_dy;
	logic [SUM_W:0]     mag;
	pix_t               mag_sat;

	always_comb begin
		abs_dx  = dx_s2[DIFF_W-1] ? SUM_W'(-dx_s2) : SUM_W'(dx_s2);
		abs_dy  = dy_s2[DIFF_W-1] ? SUM_W'(-dy_s2) : SUM_W'(dy_s2);
		mag     = (SUM_W+1)'(abs_dx) + (SUM_W+1)'(abs_dy);
		mag_sat = (mag > (SUM_W+1)'(SAT_MAX)) ? PIX_W'(SAT_MAX) : mag[PIX_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= zero_s2 ? '0 : mag_sat;
			m_axis_tlast <= last_s2;
		end
	end

	// write-back and new read never hit the same line store entry
	a_no_ram_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && acc && is_pix) |-> (col_s1 != col_q))
		else $error("line store write and read collide");

	// only a border drain output closes a frame
	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
		else $error("tlast on a non-zero output");

	// owed outputs never exceed one row plus one
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(MAX_WIDTH + 1))
		else $error("pending drain count out of range");

	// a pixel other than the last of a frame cancels any owed drain outputs
	a_pix_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_pix && !(col_wrap && row_wrap)) |=> (pend_q == '0))
		else $error("pending drain count not cleared by pixel");

endmodule
